[src/sct_pkg.sv]
// Shared types, codes and character classes of the source character tokenizer.
`default_nettype none
package sct_pkg;

    // Default parameter values
    localparam int MAX_TOKEN_LENGTH_DEF = 255;
    localparam int LINE_BITS_DEF        = 20;
    localparam int POSITION_BITS_DEF    = 32;

    // Fixed field widths of the result record
    localparam int TOKEN_LINE_W   = 20;
    localparam int TOKEN_START_W  = 32;
    localparam int TOKEN_LENGTH_W = 8;

    // Result queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    // Keyword match progress
    localparam logic [2:0] KP_FULL = 3'd4;
    localparam logic [2:0] KP_MISS = 3'd7;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_IDENT   = 3'd1,
        M_INT     = 3'd2,
        M_DOT     = 3'd3,
        M_FRAC    = 3'd4,
        M_COMMENT = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        TK_ID     = 3'd0,
        TK_FUNC   = 3'd1,
        TK_NUM    = 3'd2,
        TK_OP     = 3'd3,
        TK_END    = 3'd4,
        TK_BADNUM = 3'd5,
        TK_UNREC  = 3'd6
    } t_tok;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } t_in;

    typedef struct packed {
        logic [2:0]                token_kind;
        logic [TOKEN_LINE_W-1:0]   token_line;
        logic [TOKEN_START_W-1:0]  token_start;
        logic [TOKEN_LENGTH_W-1:0] token_length;
        logic [7:0]                token_char;
        logic                      last_of_run;
    } t_out;

    // Records produced by one accepted item, first in rec0
    typedef struct packed {
        logic [1:0] cnt;
        t_out       rec0;
        t_out       rec1;
    } t_push;

    function automatic logic [7:0] kw_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = "f";
            2'd1:    ch = "u";
            2'd2:    ch = "n";
            default: ch = "c";
        endcase
        return ch;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {" ", [8'd9:8'd13]};
    endfunction

    function automatic logic is_newline(input logic [7:0] c);
        return c inside {8'd10, 8'd13};
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return c inside {"+", "-", "/", "*", "=", ">", "<", "(", ")", "{", "}"};
    endfunction

endpackage
`default_nettype wire

[src/source_char_tokenizer_top.sv]
// Top level of the source character tokenizer: lexer plus result queue.
//
// Input channel (i_in_valid / o_in_ready / i_in_item): one source character or
// an end-of-input mark per transfer. Output channel (o_out_valid / i_out_ready /
// o_out_item): one token record per transfer; last_of_run marks the final
// record caused by an input transfer.
// A record caused by an input transfer is written into the result queue at that
// transfer and shown on the output from the queue. Throughput: one input transfer
// per cycle while the result queue has room for two records; the lexer state
// registers are updated in the same cycle the character is taken, so consecutive
// characters follow back to back.
// A character that ends a pending token and is itself an operator or an
// unrecognized byte, or an end mark with a token pending, gives two records;
// both enter the four-entry queue in the same cycle.
// Stall: when the receiver holds i_out_ready low the queue fills; o_in_ready
// drops once fewer than two entries are free and returns as records drain.
// Reset (i_rst_n low, synchronous): lexer goes idle, line, position, start,
// length and keyword progress clear, and the queue empties.
`default_nettype none
module source_char_tokenizer_top #(
    parameter int MAX_TOKEN_LENGTH = sct_pkg::MAX_TOKEN_LENGTH_DEF,
    parameter int LINE_BITS        = sct_pkg::LINE_BITS_DEF,
    parameter int POSITION_BITS    = sct_pkg::POSITION_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire sct_pkg::t_in  i_in_item,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output sct_pkg::t_out      o_out_item
);
    import sct_pkg::*;

    logic  in_accept;
    logic  q_space;
    t_push push;

    // an input transfer happens only with two free queue slots
    assign o_in_ready = q_space;
    assign in_accept  = i_in_valid && o_in_ready;

    sct_lexer #(
        .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
        .LINE_BITS        (LINE_BITS),
        .POSITION_BITS    (POSITION_BITS)
    ) u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .o_push   (push)
    );

    sct_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (q_space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    // At most two records per input transfer
    a_push_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.cnt != 2'd3)
        else $error("more than two records pushed");

    // Records are pushed only on an input transfer
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.cnt != 2'd0 |-> in_accept)
        else $error("record pushed without input transfer");

    // End mark always yields at least its end record
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_in_item.kind |-> push.cnt != 2'd0)
        else $error("end mark produced no record");

    // last_of_run sits only on the final record of the run
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt == 2'd1 |-> push.rec0.last_of_run) and
        (push.cnt == 2'd2 |-> !push.rec0.last_of_run && push.rec1.last_of_run))
        else $error("last_of_run misplaced");

endmodule
`default_nettype wire

[src/sct_lexer.sv]
// Lexer state registers and per-character token decision logic.
`default_nettype none
module sct_lexer #(
    parameter int MAX_TOKEN_LENGTH = sct_pkg::MAX_TOKEN_LENGTH_DEF,
    parameter int LINE_BITS        = sct_pkg::LINE_BITS_DEF,
    parameter int POSITION_BITS    = sct_pkg::POSITION_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire sct_pkg::t_in  i_item,
    output sct_pkg::t_push     o_push
);
    import sct_pkg::*;

    localparam int LW  = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam int LCW = (LW > TOKEN_LENGTH_W) ? LW : TOKEN_LENGTH_W;
    localparam int NCW = (LINE_BITS > TOKEN_LINE_W) ? LINE_BITS : TOKEN_LINE_W;
    localparam int PCW = (POSITION_BITS > TOKEN_START_W) ? POSITION_BITS : TOKEN_START_W;

    t_mode                    r_mode, n_mode;
    logic [LINE_BITS-1:0]     r_line, n_line;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [LW-1:0]            r_len, n_len;
    logic [2:0]               r_kp, n_kp;

    logic [7:0] c;
    logic       is_end;
    logic       used, flush, fresh, emit_char, has_second;
    logic       c_dig, c_alpha, c_nl, c_spc, c_hash;
    logic [LW-1:0]            len_grow;
    logic [LINE_BITS-1:0]     line_inc;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [LCW-1:0]           len_ext;
    logic [NCW-1:0]           line_ext;
    logic [PCW-1:0]           start_ext, pos_ext;
    logic [TOKEN_LENGTH_W-1:0] len_out;
    logic [TOKEN_LINE_W-1:0]   line_out;
    logic [TOKEN_START_W-1:0]  start_out, pos_out;
    t_out rec_flush, rec_second;
    t_tok flush_kind;

    assign c       = i_item.char_code;
    assign is_end  = i_item.kind;
    assign c_dig   = is_digit(c);
    assign c_alpha = is_alpha(c);
    assign c_nl    = is_newline(c);
    assign c_spc   = is_space(c);
    assign c_hash  = (c == "#");

    // Saturating counters
    assign len_grow = (r_len < LW'(MAX_TOKEN_LENGTH)) ? r_len + LW'(1) : r_len;
    assign line_inc = (r_line == {LINE_BITS{1'b1}}) ? r_line : r_line + LINE_BITS'(1);
    assign pos_inc  = (r_pos == {POSITION_BITS{1'b1}}) ? r_pos : r_pos + POSITION_BITS'(1);

    // Clamp to the record field widths
    assign len_ext   = LCW'(r_len);
    assign line_ext  = NCW'(r_line);
    assign start_ext = PCW'(r_start);
    assign pos_ext   = PCW'(r_pos);
    assign len_out   = (len_ext > LCW'({TOKEN_LENGTH_W{1'b1}})) ? {TOKEN_LENGTH_W{1'b1}}
                                                                 : len_ext[TOKEN_LENGTH_W-1:0];
    assign line_out  = (line_ext > NCW'({TOKEN_LINE_W{1'b1}})) ? {TOKEN_LINE_W{1'b1}}
                                                                : line_ext[TOKEN_LINE_W-1:0];
    assign start_out = (start_ext > PCW'({TOKEN_START_W{1'b1}})) ? {TOKEN_START_W{1'b1}}
                                                                  : start_ext[TOKEN_START_W-1:0];
    assign pos_out   = (pos_ext > PCW'({TOKEN_START_W{1'b1}})) ? {TOKEN_START_W{1'b1}}
                                                              : pos_ext[TOKEN_START_W-1:0];

    // Does the current token take this character, or does it end here
    always_comb begin
        used  = 1'b0;
        flush = 1'b0;
        if (is_end) begin
            flush = (r_mode == M_IDENT) || (r_mode == M_INT) ||
                    (r_mode == M_DOT) || (r_mode == M_FRAC);
        end else begin
            case (r_mode)
                M_IDENT: begin
                    used  = c_alpha || c_dig;
                    flush = !(c_alpha || c_dig);
                end
                M_INT: begin
                    used  = c_dig || (c == ".");
                    flush = !(c_dig || (c == "."));
                end
                M_DOT, M_FRAC: begin
                    used  = c_dig;
                    flush = !c_dig;
                end
                M_COMMENT: used = 1'b1;
                default: ;
            endcase
        end
    end

    // Character not taken by a token: start something new or emit it
    assign fresh      = !is_end && !used;
    assign emit_char  = fresh && !c_nl && !c_spc && !c_alpha && !c_dig && !c_hash;
    assign has_second = is_end || emit_char;

    // Next state
    always_comb begin
        n_mode  = r_mode;
        n_line  = r_line;
        n_pos   = r_pos;
        n_start = r_start;
        n_len   = r_len;
        n_kp    = r_kp;
        if (is_end) begin
            n_mode = M_IDLE;
        end else begin
            case (r_mode)
                M_IDENT: begin
                    if (used) begin
                        n_len = len_grow;
                        if (r_kp < KP_FULL && c == kw_char(r_kp[1:0])) begin
                            n_kp = r_kp + 3'd1;
                        end else begin
                            n_kp = KP_MISS;
                        end
                    end
                end
                M_INT: begin
                    if (c_dig) begin
                        n_len = len_grow;
                    end else if (c == ".") begin
                        n_len  = len_grow;
                        n_mode = M_DOT;
                    end
                end
                M_DOT, M_FRAC: begin
                    if (c_dig) begin
                        n_len  = len_grow;
                        n_mode = M_FRAC;
                    end
                end
                M_COMMENT: begin
                    if (c_nl) begin
                        n_line = line_inc;
                        n_mode = M_IDLE;
                    end
                end
                default: n_mode = M_IDLE;
            endcase
            if (flush) begin
                n_mode = M_IDLE;
            end
            if (fresh) begin
                if (c_nl) begin
                    n_line = line_inc;
                end else if (c_spc) begin
                    n_mode = M_IDLE;
                end else if (c_alpha) begin
                    n_mode  = M_IDENT;
                    n_start = r_pos;
                    n_len   = LW'(1);
                    n_kp    = (c == kw_char(2'd0)) ? 3'd1 : KP_MISS;
                end else if (c_dig) begin
                    n_mode  = M_INT;
                    n_start = r_pos;
                    n_len   = LW'(1);
                end else if (c_hash) begin
                    n_mode = M_COMMENT;
                end
            end
            n_pos = pos_inc;
        end
    end

    // Result records
    always_comb begin
        case (r_mode)
            M_IDENT:       flush_kind = (r_kp == KP_FULL) ? TK_FUNC : TK_ID;
            M_INT, M_FRAC: flush_kind = TK_NUM;
            default:       flush_kind = TK_BADNUM;
        endcase

        rec_flush.token_kind   = flush_kind;
        rec_flush.token_line   = line_out;
        rec_flush.token_start  = start_out;
        rec_flush.token_length = len_out;
        rec_flush.token_char   = 8'd0;
        rec_flush.last_of_run  = !has_second;

        rec_second.token_line  = line_out;
        rec_second.token_start = pos_out;
        rec_second.last_of_run = 1'b1;
        if (is_end) begin
            rec_second.token_kind   = TK_END;
            rec_second.token_length = '0;
            rec_second.token_char   = 8'd0;
        end else begin
            rec_second.token_kind   = is_oper(c) ? TK_OP : TK_UNREC;
            rec_second.token_length = TOKEN_LENGTH_W'(1);
            rec_second.token_char   = c;
        end

        o_push.rec0 = flush ? rec_flush : rec_second;
        o_push.rec1 = rec_second;
        o_push.cnt  = i_accept ? (2'(flush) + 2'(has_second)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_line  <= '0;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_kp    <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
            r_kp    <= n_kp;
        end
    end

endmodule
`default_nettype wire

[src/sct_outq.sv]
// Four-entry result queue taking up to two records per cycle.
`default_nettype none
module sct_outq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sct_pkg::t_push i_push,
    output logic                o_space,
    output logic                o_valid,
    input  wire logic           i_ready,
    output sct_pkg::t_out       o_item
);
    import sct_pkg::*;

    t_out             r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wr, n_wr;
    logic [OQ_AW-1:0] r_rd, n_rd;
    logic [OQ_CW-1:0] r_cnt, n_cnt;
    logic             pop;

    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    // room for a double result regardless of the consumer
    assign o_space = (r_cnt <= OQ_CW'(OQ_DEPTH - 2));

    always_comb begin
        n_wr  = r_wr + OQ_AW'(i_push.cnt);
        n_rd  = pop ? r_rd + OQ_AW'(1) : r_rd;
        n_cnt = r_cnt + OQ_CW'(i_push.cnt) - OQ_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.rec0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + OQ_AW'(1)] <= i_push.rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

[tb/tb_source_char_tokenizer_top.sv]
// Self-checking testbench for the source character tokenizer top level.
module tb_source_char_tokenizer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sct_pkg::*;

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int RANDOM_ITEMS = 650;       // transfers in the random stream
    localparam int HOLD_CYCLES  = 300;       // long receiver hold-off
    localparam int DRAIN_GAP    = 8;         // settle cycles after the queue empties
    localparam int CYCLE_LIMIT  = 400000;    // hard stop for a hung run
    localparam int MAX_REPORTS  = 10;        // mismatches printed in full

    localparam logic [7:0]  CH_TAB   = 8'd9;
    localparam logic [7:0]  CH_LF    = 8'd10;
    localparam logic [7:0]  CH_CR    = 8'd13;
    localparam logic [31:0] FUNC_WORD = "func";
    localparam logic [87:0] OPER_SET  = "+-/*=><(){}";
    localparam logic [7:0]  LEN_MAX   = 8'(MAX_TOKEN_LENGTH_DEF);

    // Receiver stall styles
    typedef enum logic [1:0] {
        RX_OPEN,   // always ready
        RX_COIN,   // ready on a coin flip each cycle
        RX_RUNS    // alternating runs of stall and ready
    } t_rx_style;

    // ------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ------------------------------------------------------------------
    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_item   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_item;

    always #2 clk = ~clk;

    source_char_tokenizer_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // ------------------------------------------------------------------
    // Lexer shadow state, updated once per accepted input transfer
    // ------------------------------------------------------------------
    t_mode       lx_mode  = M_IDLE;
    logic [19:0] lx_line  = '0;
    logic [31:0] lx_pos   = '0;
    logic [31:0] lx_start = '0;
    logic [7:0]  lx_len   = '0;
    logic [2:0]  lx_kwp   = '0;

    t_out token_q[$];      // token records still owed by the DUT
    t_out step_recs[$];    // records produced by the transfer being predicted

    // Bookkeeping
    int sent_cnt   = 0;
    int end_cnt    = 0;
    int pair_cnt   = 0;
    int rec_cnt    = 0;
    int err_cnt    = 0;
    int cycle_cnt  = 0;
    int burst_left = 0;
    bit steady     = 1'b0;   // sender offers back to back, no gaps

    // Hold-off request: the test flips it, the receiver counts the stretch
    logic hold_req  = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    // ------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------
    function automatic bit ch_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit ch_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit ch_newline(input logic [7:0] c);
        return c == CH_LF || c == CH_CR;
    endfunction

    function automatic bit ch_blank(input logic [7:0] c);
        return c == " " || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit ch_oper(input logic [7:0] c);
        bit hit;
        hit = 1'b0;
        for (int k = 0; k < 11; k++)
            if (c == OPER_SET[8*k +: 8]) hit = 1'b1;
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------
    function automatic t_out token_rec(input t_tok k, input logic [31:0] st,
                                       input logic [7:0] len, input logic [7:0] ch);
        t_out r;
        r.token_kind   = k;
        r.token_line   = lx_line;
        r.token_start  = st;
        r.token_length = len;
        r.token_char   = ch;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    function automatic void bump_line();
        if (lx_line != '1) lx_line = lx_line + 1'b1;
    endfunction

    function automatic void bump_len();
        if (lx_len < LEN_MAX) lx_len = lx_len + 1'b1;
    endfunction

    function automatic void open_token(input t_mode m, input logic [31:0] pos);
        lx_mode  = m;
        lx_start = pos;
        lx_len   = 8'd1;
    endfunction

    // Emit the token under construction, if any, and go idle
    function automatic void close_token();
        t_tok k;
        bit   hit;
        k   = TK_ID;
        hit = 1'b1;
        case (lx_mode)
            M_IDENT: begin
                if (lx_kwp == KP_FULL) k = TK_FUNC;
                else k = TK_ID;
            end
            M_INT, M_FRAC: k = TK_NUM;
            M_DOT:         k = TK_BADNUM;
            default:       hit = 1'b0;
        endcase
        if (hit) step_recs.push_back(token_rec(k, lx_start, lx_len, 8'd0));
        lx_mode = M_IDLE;
    endfunction

    function automatic void predict_transfer(input t_in itm);
        logic [31:0] pos;
        logic [7:0]  c;
        bit          taken;
        pos   = lx_pos;
        c     = itm.char_code;
        taken = 1'b0;
        step_recs.delete();

        if (itm.kind) begin
            // end mark: pending token first, a pending comment just vanishes
            close_token();
            step_recs.push_back(token_rec(TK_END, pos, 8'd0, 8'd0));
            end_cnt++;
        end else begin
            case (lx_mode)
                M_IDENT: begin
                    if (ch_letter(c) || ch_digit(c)) begin
                        bump_len();
                        if (lx_kwp < KP_FULL && c == FUNC_WORD[8*(3-int'(lx_kwp)) +: 8])
                            lx_kwp = lx_kwp + 1'b1;
                        else
                            lx_kwp = KP_MISS;
                        taken = 1'b1;
                    end else begin
                        close_token();
                    end
                end
                M_INT: begin
                    if (ch_digit(c)) begin
                        bump_len();
                        taken = 1'b1;
                    end else if (c == ".") begin
                        bump_len();
                        lx_mode = M_DOT;
                        taken   = 1'b1;
                    end else begin
                        close_token();
                    end
                end
                M_DOT, M_FRAC: begin
                    if (ch_digit(c)) begin
                        bump_len();
                        lx_mode = M_FRAC;
                        taken   = 1'b1;
                    end else begin
                        close_token();
                    end
                end
                M_COMMENT: begin
                    if (ch_newline(c)) begin
                        bump_line();
                        lx_mode = M_IDLE;
                    end
                    taken = 1'b1;
                end
                default: lx_mode = M_IDLE;
            endcase

            // the character that ended a token is looked at again here
            if (!taken) begin
                if (ch_newline(c)) begin
                    bump_line();
                end else if (ch_blank(c)) begin
                    // separator, nothing to do
                end else if (ch_letter(c)) begin
                    open_token(M_IDENT, pos);
                    lx_kwp = (c == FUNC_WORD[31:24]) ? 3'd1 : KP_MISS;
                end else if (ch_digit(c)) begin
                    open_token(M_INT, pos);
                end else if (c == "#") begin
                    lx_mode = M_COMMENT;
                end else if (ch_oper(c)) begin
                    step_recs.push_back(token_rec(TK_OP, pos, 8'd1, c));
                end else begin
                    step_recs.push_back(token_rec(TK_UNREC, pos, 8'd1, c));
                end
            end

            if (lx_pos != '1) lx_pos = lx_pos + 1'b1;
        end

        if (step_recs.size() > 0) step_recs[step_recs.size()-1].last_of_run = 1'b1;
        if (step_recs.size() == 2) pair_cnt++;
        foreach (step_recs[i]) token_q.push_back(step_recs[i]);
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps. Valid is lowered
    // only when a gap follows, so it never toggles inside one step.
    // ------------------------------------------------------------------
    task automatic send_item(input logic is_end, input logic [7:0] code);
        t_in itm;
        int  gap;
        if (!steady) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 12);
            end
            burst_left--;
        end
        itm.kind      = is_end;
        itm.char_code = code;
        in_valid <= 1'b1;
        in_item  <= itm;
        @(posedge clk);
        while (!(in_valid && in_ready)) @(posedge clk);
        // transfer happened at this edge
        predict_transfer(itm);
        sent_cnt++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
    endtask

    task automatic send_end();
        send_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // Wait until every owed record is out, then let the pipe settle
    task automatic drain_tokens();
        in_valid <= 1'b0;
        while (token_q.size() != 0) @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_alnum();
        return ($urandom_range(0, 3) == 0) ? pick_digit() : pick_letter();
    endfunction

    function automatic logic [7:0] pick_oper();
        return OPER_SET[8*$urandom_range(0, 10) +: 8];
    endfunction

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern, plus the long hold-off on request
    // ------------------------------------------------------------------
    t_rx_style rx_style = RX_OPEN;
    int        rx_left  = 0;
    int        run_left = 0;
    bit        run_hi   = 1'b0;

    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_style = t_rx_style'($urandom_range(0, 2));
                rx_left  = $urandom_range(40, 300);
            end
            rx_left--;
            case (rx_style)
                RX_OPEN: out_ready <= 1'b1;
                RX_COIN: out_ready <= 1'($urandom_range(0, 1));
                default: begin
                    if (run_left == 0) begin
                        run_hi   = !run_hi;
                        run_left = run_hi ? $urandom_range(1, 4) : $urandom_range(1, 12);
                    end
                    run_left--;
                    out_ready <= run_hi;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each transfer on the output against the oldest owed record
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            rec_cnt++;
            if (token_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("[%0t] unexpected token record: kind %0d start %0d len %0d",
                             $realtime, out_item.token_kind, out_item.token_start,
                             out_item.token_length);
            end else begin
                want = token_q.pop_front();
                if (out_item !== want) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS) begin
                        $display("[%0t] token record mismatch (expected / actual):",
                                 $realtime);
                        $display("    kind %0d/%0d line %0d/%0d start %0d/%0d",
                                 want.token_kind, out_item.token_kind,
                                 want.token_line, out_item.token_line,
                                 want.token_start, out_item.token_start);
                        $display("    length %0d/%0d char %02h/%02h last %0b/%0b",
                                 want.token_length, out_item.token_length,
                                 want.token_char, out_item.token_char,
                                 want.last_of_run, out_item.last_of_run);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d records still owed",
                     cycle_cnt, token_q.size());
            $display("source_char_tokenizer_top verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Keyword, identifier, operator, fraction then second dot, comment with
    // newline, dot without digit ended by a letter, identifier ended by CR, stray bytes,
    // pending identifier at end of input and a repeated end mark.
    task automatic test_directed_cases();
        send_text("func fn1+3.1.#c");
        send_item(1'b0, CH_LF);
        send_text("7.x");
        send_item(1'b0, CH_CR);
        send_text("@");
        send_item(1'b0, 8'hFF);
        send_text("a");
        send_end();
        send_end();
        drain_tokens();
    endtask

    // Identifier and number longer than the length field can hold, then a
    // comment left open when the end mark arrives.
    task automatic test_length_saturation();
        send_text("f");
        repeat (269) send_item(1'b0, pick_alnum());
        send_text(" ");
        repeat (260) send_item(1'b0, pick_digit());
        send_text(".");
        repeat (5) send_item(1'b0, pick_digit());
        send_text(".#xx");
        send_end();
        drain_tokens();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    // letter/operator pairs; each operator yields two records, so the queue
    // fills and the input must stall.
    task automatic test_output_backpressure();
        steady = 1'b1;
        hold_req <= ~hold_req;
        repeat (20) begin
            send_item(1'b0, pick_letter());
            send_item(1'b0, pick_oper());
        end
        send_end();
        steady = 1'b0;
        drain_tokens();
    endtask

    // Mostly well-formed fragments with random content; noise bytes, open
    // comments and end marks mixed in. Fragments abut, so tokens end on
    // every kind of neighbor.
    task automatic test_random_stream();
        int first;
        int pick;
        int n;
        first = sent_cnt;
        while (sent_cnt - first < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                if ($urandom_range(0, 3) == 0) begin
                    // keyword, a prefix of it, or a longer word starting with it
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++) send_item(1'b0, FUNC_WORD[8*(3-i) +: 8]);
                    repeat ($urandom_range(0, 2)) send_item(1'b0, pick_alnum());
                end else begin
                    send_item(1'b0, pick_letter());
                    repeat ($urandom_range(0, 7)) send_item(1'b0, pick_alnum());
                end
            end else if (pick < 50) begin
                repeat ($urandom_range(1, 5)) send_item(1'b0, pick_digit());
                if ($urandom_range(0, 1)) begin
                    send_text(".");
                    repeat ($urandom_range(0, 3)) send_item(1'b0, pick_digit());
                    if ($urandom_range(0, 5) == 0) send_text(".");
                end
            end else if (pick < 65) begin
                send_item(1'b0, pick_oper());
            end else if (pick < 78) begin
                case ($urandom_range(0, 5))
                    0:       send_item(1'b0, CH_LF);
                    1:       send_item(1'b0, CH_CR);
                    2:       send_item(1'b0, CH_TAB);
                    3:       send_item(1'b0, 8'($urandom_range(11, 12)));
                    default: send_text(" ");
                endcase
            end else if (pick < 86) begin
                send_text("#");
                repeat ($urandom_range(0, 6)) send_item(1'b0, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 4) != 0)
                    send_item(1'b0, $urandom_range(0, 1) ? CH_LF : CH_CR);
            end else if (pick < 96) begin
                send_item(1'b0, 8'($urandom_range(0, 255)));
            end else begin
                send_end();
            end
        end
        send_end();
        drain_tokens();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_length_saturation();
        test_output_backpressure();
        test_random_stream();

        $display("covered %0d input transfers (%0d end marks), %0d token records checked",
                 sent_cnt, end_cnt, rec_cnt);
        $display("%0d transfers gave two records; long tokens and a %0d-cycle output stall",
                 pair_cnt, HOLD_CYCLES);
        if (err_cnt == 0 && token_q.size() == 0) begin
            $display("source_char_tokenizer_top verification clean");
        end else begin
            $display("%0d mismatches, %0d records never seen", err_cnt, token_q.size());
            $display("source_char_tokenizer_top verification failed");
        end
        $finish;
    end

endmodule
